FILE: rtl/qrs_pkg.sv
package qrs_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_HP_GAIN       = 2'd0;
    localparam logic [1:0] REG_FORGET_FACTOR = 2'd1;
    localparam logic [1:0] REG_THR_WINDOW    = 2'd2;
    localparam logic [1:0] REG_HOLDOFF       = 2'd3;

    // reset values of the configuration registers
    localparam logic [15:0] HP_GAIN_RST       = 16'd9362;
    localparam logic [12:0] FORGET_FACTOR_RST = 13'd3604;
    localparam logic [9:0]  THR_WINDOW_RST    = 10'd250;
    localparam logic [7:0]  HOLDOFF_RST       = 8'd100;

    // 0.175 in Q0.16
    localparam logic [13:0] GAMMA_Q16   = 14'd11469;
    localparam logic [39:0] MAX40       = 40'hFF_FFFF_FFFF;
    localparam logic [9:0]  STARTUP_MAX = 10'd1023;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_HPMUL,
        S_HP,
        S_SQ,
        S_SQO,
        S_EN,
        S_EVAL,
        S_DEC,
        S_AG,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_TSUM,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUM,
        OP_HPMUL,
        OP_HP,
        OP_SQ,
        OP_SQO,
        OP_EN,
        OP_EVAL,
        OP_DEC,
        OP_AG,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_TSUM,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic need_update;
    } status_t;

endpackage

FILE: rtl/qrs_beat_detector.sv
// QRS beat detector. One signed 16-bit ECG sample per input transaction gives one
// result transaction: the beat flag, the moving energy of the high-pass output and
// the threshold it was compared against. Each sample runs through the sequence to
// its result before the next sample is accepted; the threshold adjustment steps run
// only when a window completes, and writing the result waits while the previous
// result still waits to be taken. The
// sequencer walks one item at a time through the shared squarer and the shared
// 27x20 multiplier of the threshold step. The result sits in an output register
// until taken. HP_LEN and LP_LEN set the high-pass and energy window lengths
// (shift lines of HP_LEN and LP_LEN taps).
module qrs_beat_detector
    import qrs_pkg::*;
#(
    parameter int HP_LEN = 7,
    parameter int LP_LEN = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               beat_detected,
    output logic [39:0]        energy,
    output logic [39:0]        current_threshold,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    qrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qrs_datapath #(
        .HP_LEN (HP_LEN),
        .LP_LEN (LP_LEN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .sample            (sample),
        .cmd               (cmd),
        .status            (status),
        .beat_detected     (beat_detected),
        .energy            (energy),
        .current_threshold (current_threshold)
    );

    // one item in flight: no new transaction right after one is accepted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // a flagged beat always has energy above its threshold
    a_beat_above: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beat_detected) |-> (energy > current_threshold))
        else $error("beat flagged without energy above threshold");

    // a new result appears only while the sequencer is busy
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

endmodule

FILE: rtl/qrs_ctrl.sv
module qrs_ctrl
    import qrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SUM;
            S_SUM:   state_next = S_HPMUL;
            S_HPMUL: state_next = S_HP;
            S_HP:    state_next = S_SQ;
            S_SQ:    state_next = S_SQO;
            S_SQO:   state_next = S_EN;
            S_EN:    state_next = S_EVAL;
            S_EVAL:  state_next = S_DEC;
            S_DEC:   state_next = status.need_update ? S_AG : S_OUT;
            S_AG:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_P4;
            S_P4:    state_next = S_TSUM;
            S_TSUM:  state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands and result valid
    always_comb
    begin
        cmd.op         = OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
            S_SUM:   cmd.op = OP_SUM;
            S_HPMUL: cmd.op = OP_HPMUL;
            S_HP:    cmd.op = OP_HP;
            S_SQ:    cmd.op = OP_SQ;
            S_SQO:   cmd.op = OP_SQO;
            S_EN:    cmd.op = OP_EN;
            S_EVAL:  cmd.op = OP_EVAL;
            S_DEC:   cmd.op = OP_DEC;
            S_AG:    cmd.op = OP_AG;
            S_P1:    cmd.op = OP_P1;
            S_P2:    cmd.op = OP_P2;
            S_P3:    cmd.op = OP_P3;
            S_P4:    cmd.op = OP_P4;
            S_TSUM:  cmd.op = OP_TSUM;
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/qrs_datapath.sv
module qrs_datapath
    import qrs_pkg::*;
#(
    parameter int HP_LEN = 7,
    parameter int LP_LEN = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic signed [15:0] sample,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               beat_detected,
    output logic [39:0]        energy,
    output logic [39:0]        current_threshold
);

    localparam int CTR   = (HP_LEN + 1) / 2;
    localparam int RS_W  = 17 + $clog2(HP_LEN + 1);
    localparam int PR_W  = RS_W + 17;
    localparam int ES_R  = 35 + $clog2(LP_LEN + 1);
    localparam int ES_W  = (ES_R > 41) ? ES_R : 41;
    localparam logic signed [PR_W:0] HP_MAX = 131071;
    localparam logic signed [PR_W:0] HP_MIN = -131072;

    // configuration
    logic [15:0] hp_gain_reg;
    logic [12:0] alpha_reg;
    logic [9:0]  tw_reg;
    logic [7:0]  hs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_gain_reg <= HP_GAIN_RST;
            alpha_reg   <= FORGET_FACTOR_RST;
            tw_reg      <= THR_WINDOW_RST;
            hs_reg      <= HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HP_GAIN:       hp_gain_reg <= cfg_wdata;
                REG_FORGET_FACTOR: alpha_reg   <= cfg_wdata[12:0];
                REG_THR_WINDOW:    tw_reg      <= cfg_wdata[9:0];
                REG_HOLDOFF:       hs_reg      <= cfg_wdata[7:0];
                default:           hs_reg      <= hs_reg;
            endcase
        end
    end

    // state
    logic signed [15:0]     x_reg;
    logic signed [15:0]     raw_line [HP_LEN];
    logic signed [17:0]     hp_line  [LP_LEN];
    logic signed [RS_W-1:0] raw_sum_reg;
    logic signed [15:0]     center_reg;
    logic                   hp_on_reg, lp_on_reg;
    logic signed [PR_W-1:0] prod_reg;
    logic signed [17:0]     hp_reg;
    logic [34:0]            sq_reg, sqo_reg;
    logic [ES_W-1:0]        es_reg;
    logic [39:0]            energy_reg, thr_reg, peak_reg, thr_out_reg;
    logic [9:0]             startup_reg, wc_reg;
    logic                   hold_reg, beat_reg;
    logic [7:0]             hold_cnt_reg;
    logic [26:0]            ag_reg;
    logic [66:0]            acc1_reg;
    logic [56:0]            acc2_reg;
    logic                   out_beat_reg;
    logic [39:0]            out_energy_reg, out_thr_reg;

    // high-pass rounding and saturation
    logic signed [PR_W-1:0] rnd, y1;
    logic signed [PR_W:0]   ydiff;
    logic signed [17:0]     y_sat;

    always_comb
    begin
        rnd   = prod_reg + PR_W'(32768);
        y1    = rnd >>> 16;
        ydiff = (PR_W + 1)'(center_reg) - (PR_W + 1)'(y1);
        if (ydiff > HP_MAX)
            y_sat = 18'sh1FFFF;
        else if (ydiff < HP_MIN)
            y_sat = 18'sh20000;
        else
            y_sat = ydiff[17:0];
    end

    // shared squarer
    logic signed [17:0] sq_a;
    logic signed [35:0] sq_p;
    assign sq_a = (cmd.op == OP_SQ) ? hp_reg : hp_line[LP_LEN-1];
    assign sq_p = sq_a * sq_a;

    // energy update
    logic [ES_W-1:0] es_new;
    logic [39:0]     energy_c;
    always_comb
    begin
        es_new = es_reg + ES_W'(sq_reg) - ES_W'(sqo_reg);
        if (!lp_on_reg)
            energy_c = '0;
        else if (es_new[ES_W-1:40] != '0)
            energy_c = MAX40;
        else
            energy_c = es_new[39:0];
    end

    // startup threshold and hold-off
    logic [39:0] thr1;
    logic [7:0]  hcnt_inc;
    assign thr1     = (startup_reg < tw_reg && energy_reg > thr_reg) ? energy_reg : thr_reg;
    assign hcnt_inc = hold_cnt_reg + 8'd1;

    // beat decision
    logic beat_c;
    assign beat_c             = (energy_reg > thr_reg) && !hold_reg;
    assign status.need_update = !beat_c && (wc_reg >= tw_reg);

    // shared multiplier for the threshold step
    logic [26:0] mul_a;
    logic [19:0] mul_b;
    logic [46:0] mul_p;
    logic [26:0] m_fac;
    assign m_fac = 27'(17'h10000 - {4'd0, alpha_reg});
    always_comb
    begin
        case (cmd.op)
            OP_P1:   begin mul_a = ag_reg; mul_b = peak_reg[39:20]; end
            OP_P2:   begin mul_a = ag_reg; mul_b = peak_reg[19:0];  end
            OP_P3:   begin mul_a = m_fac;  mul_b = thr_reg[39:20];  end
            default: begin mul_a = m_fac;  mul_b = thr_reg[19:0];   end
        endcase
    end
    assign mul_p = 47'(mul_a) * 47'(mul_b);

    logic [41:0] tsum;
    assign tsum = 42'(acc1_reg[66:32]) + 42'(acc2_reg[56:16]);

    // sequenced datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HP_LEN; i++) raw_line[i] <= '0;
            for (int i = 0; i < LP_LEN; i++) hp_line[i] <= '0;
            x_reg          <= '0;
            raw_sum_reg    <= '0;
            center_reg     <= '0;
            hp_on_reg      <= 1'b0;
            lp_on_reg      <= 1'b0;
            prod_reg       <= '0;
            hp_reg         <= '0;
            sq_reg         <= '0;
            sqo_reg        <= '0;
            es_reg         <= '0;
            energy_reg     <= '0;
            thr_reg        <= '0;
            peak_reg       <= '0;
            thr_out_reg    <= '0;
            startup_reg    <= '0;
            wc_reg         <= '0;
            hold_reg       <= 1'b0;
            hold_cnt_reg   <= '0;
            beat_reg       <= 1'b0;
            ag_reg         <= '0;
            acc1_reg       <= '0;
            acc2_reg       <= '0;
            out_beat_reg   <= 1'b0;
            out_energy_reg <= '0;
            out_thr_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD: x_reg <= sample;
                OP_SUM:
                begin
                    raw_sum_reg <= raw_sum_reg + RS_W'(x_reg) - RS_W'(raw_line[HP_LEN-1]);
                    center_reg  <= raw_line[CTR-1];
                    raw_line[0] <= x_reg;
                    for (int i = 1; i < HP_LEN; i++) raw_line[i] <= raw_line[i-1];
                    hp_on_reg   <= (startup_reg >= 10'(HP_LEN));
                    lp_on_reg   <= (startup_reg >= 10'(LP_LEN));
                end
                OP_HPMUL: prod_reg <= PR_W'(signed'({1'b0, hp_gain_reg})) * PR_W'(raw_sum_reg);
                OP_HP:    hp_reg   <= hp_on_reg ? y_sat : 18'sd0;
                OP_SQ:    sq_reg   <= sq_p[34:0];
                OP_SQO:   sqo_reg  <= sq_p[34:0];
                OP_EN:
                begin
                    es_reg     <= es_new;
                    energy_reg <= energy_c;
                    hp_line[0] <= hp_reg;
                    for (int i = 1; i < LP_LEN; i++) hp_line[i] <= hp_line[i-1];
                end
                OP_EVAL:
                begin
                    thr_reg <= thr1;
                    if (startup_reg < STARTUP_MAX)
                        startup_reg <= startup_reg + 10'd1;
                    if (hold_reg)
                    begin
                        if (hcnt_inc >= hs_reg)
                        begin
                            hold_reg     <= 1'b0;
                            hold_cnt_reg <= '0;
                        end
                        else
                            hold_cnt_reg <= hcnt_inc;
                    end
                    if (energy_reg > peak_reg)
                        peak_reg <= energy_reg;
                end
                OP_DEC:
                begin
                    beat_reg    <= beat_c;
                    thr_out_reg <= thr_reg;
                    if (beat_c)
                        hold_reg <= 1'b1;
                    else if (wc_reg >= tw_reg)
                        wc_reg <= '0;
                    else
                        wc_reg <= wc_reg + 10'd1;
                end
                OP_AG:   ag_reg   <= 27'(alpha_reg) * 27'(GAMMA_Q16);
                OP_P1:   acc1_reg <= {mul_p, 20'd0};
                OP_P2:   acc1_reg <= acc1_reg + 67'(mul_p) + 67'h8000_0000;
                OP_P3:   acc2_reg <= {mul_p[36:0], 20'd0};
                OP_P4:   acc2_reg <= acc2_reg + 57'(mul_p) + 57'd32768;
                OP_TSUM:
                begin
                    thr_reg  <= (tsum[41:40] != 2'd0) ? MAX40 : tsum[39:0];
                    peak_reg <= '0;
                end
                OP_OUT:
                begin
                    out_beat_reg   <= beat_reg;
                    out_energy_reg <= energy_reg;
                    out_thr_reg    <= thr_out_reg;
                end
                default: x_reg <= x_reg;
            endcase
        end
    end

    assign beat_detected     = out_beat_reg;
    assign energy            = out_energy_reg;
    assign current_threshold = out_thr_reg;

endmodule

FILE: verif/qrs_beat_checker.sv
module qrs_beat_checker
    import qrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               beat_detected,
    input  logic [39:0]        energy,
    input  logic [39:0]        current_threshold,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HPL = 7;
    localparam int LPL = 31;

    typedef struct packed {
        logic        beat;
        logic [39:0] en;
        logic [39:0] thr;
    } beat_result_t;

    beat_result_t result_q[$];

    // predictor configuration
    logic [15:0] gain;
    logic [12:0] alpha;
    logic [9:0]  win_len;
    logic [7:0]  hold_len;

    // predictor state
    int          raw_hist[HPL+1];
    int          hp_hist[LPL+1];
    longint      acc_raw;
    logic [63:0] acc_energy;
    int          raw_pos;
    int          hp_pos;
    logic [63:0] thr_val;
    logic [63:0] peak_val;
    logic [9:0]  win_cnt;
    logic [9:0]  seen_cnt;
    logic        hold_on;
    logic [7:0]  hold_cnt;

    function automatic logic [63:0] sq64(int v);
        longint w;
        w = v;
        return 64'(w * w);
    endfunction

    function automatic logic [63:0] sat40(logic [63:0] v);
        return (v > 64'(MAX40)) ? 64'(MAX40) : v;
    endfunction

    // threshold step toward gamma times window peak
    function automatic logic [63:0] step_threshold(logic [63:0] thr, logic [63:0] pk,
                                                   logic [12:0] a);
        logic [127:0] t1;
        logic [63:0]  t2;
        t1 = (128'(a) * 128'(GAMMA_Q16) * 128'(pk) + 128'h8000_0000) >> 32;
        t2 = (64'(17'd65536 - 17'(a)) * thr + 64'd32768) >> 16;
        return sat40(64'(t1) + t2);
    endfunction

    function automatic beat_result_t predict_sample(logic signed [15:0] s);
        beat_result_t r;
        int           x;
        int           hp;
        longint       y;
        longint       prod;
        logic [63:0]  en;
        logic [9:0]   idx;
        x = s;
        hp = 0;
        en = 0;
        raw_hist[raw_pos] = x;
        acc_raw += x;
        if (seen_cnt >= HPL)
        begin
            acc_raw -= raw_hist[(raw_pos + 1) % (HPL + 1)];
            prod = longint'(gain) * acc_raw + 32768;
            y = raw_hist[(raw_pos + (HPL + 1) - (HPL + 1) / 2) % (HPL + 1)] - (prod >>> 16);
            if (y > 131071) y = 131071;
            if (y < -131072) y = -131072;
            hp = int'(y);
        end
        raw_pos = (raw_pos + 1) % (HPL + 1);
        hp_hist[hp_pos] = hp;
        acc_energy += sq64(hp);
        if (seen_cnt >= LPL)
        begin
            acc_energy -= sq64(hp_hist[(hp_pos + 1) % (LPL + 1)]);
            en = sat40(acc_energy);
        end
        hp_pos = (hp_pos + 1) % (LPL + 1);
        if (seen_cnt < win_len && en > thr_val) thr_val = en;
        if (seen_cnt < STARTUP_MAX) seen_cnt++;
        if (hold_on)
        begin
            hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt >= hold_len)
            begin
                hold_on = 1'b0;
                hold_cnt = 0;
            end
        end
        if (en > peak_val) peak_val = en;
        r.en = en[39:0];
        r.thr = thr_val[39:0];
        r.beat = 1'b0;
        if (en > thr_val && !hold_on)
        begin
            hold_on = 1'b1;
            r.beat = 1'b1;
        end
        else
        begin
            idx = win_cnt;
            win_cnt = win_cnt + 10'd1;
            if (idx >= win_len)
            begin
                thr_val = step_threshold(thr_val, peak_val, alpha);
                win_cnt = 0;
                peak_val = 0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_result_t exp_r;
        if (!rst_n)
        begin
            fail_count = 0;
            pending <= 0;
            result_q.delete();
            gain = HP_GAIN_RST;
            alpha = FORGET_FACTOR_RST;
            win_len = THR_WINDOW_RST;
            hold_len = HOLDOFF_RST;
            foreach (raw_hist[i]) raw_hist[i] = 0;
            foreach (hp_hist[i]) hp_hist[i] = 0;
            acc_raw = 0;
            acc_energy = 0;
            raw_pos = 0;
            hp_pos = 0;
            thr_val = 0;
            peak_val = 0;
            win_cnt = 0;
            seen_cnt = 0;
            hold_on = 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HP_GAIN:       gain = cfg_wdata;
                    REG_FORGET_FACTOR: alpha = cfg_wdata[12:0];
                    REG_THR_WINDOW:    win_len = cfg_wdata[9:0];
                    REG_HOLDOFF:       hold_len = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // result transaction
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result transaction with none expected", 40'd1, 40'd0);
                else
                begin
                    exp_r = result_q.pop_front();
                    if (beat_detected !== exp_r.beat)
                        report_mismatch("beat_detected", 40'(beat_detected), 40'(exp_r.beat));
                    if (energy !== exp_r.en)
                        report_mismatch("energy", energy, exp_r.en);
                    if (current_threshold !== exp_r.thr)
                        report_mismatch("current_threshold", current_threshold, exp_r.thr);
                end
            end
            // input transaction
            if (in_valid && in_ready)
                result_q.push_back(predict_sample(sample));
            pending <= result_q.size();
        end
    end
endmodule

FILE: verif/qrs_beat_detector_test.sv
module qrs_beat_detector_test;
    import qrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               beat_detected;
    logic [39:0]        energy;
    logic [39:0]        current_threshold;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_HP_GAIN;
    logic [15:0]        cfg_wdata = '0;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 out_gap = 0;

    qrs_beat_detector u_dut (.*);

    qrs_beat_checker u_chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls: a random pause after each taken result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    out_gap <= gap_len();
            end
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays high after acceptance only when the next sample follows at once
    task automatic send_sample(logic signed [15:0] s, bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // synthetic ECG: baseline noise with periodic sharp spikes and random full-scale outliers
    task automatic send_ecg(int n, int period, int amp);
        int k;
        int v;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                v = $urandom_range(0, 65535) - 32768;
            else if ((k % period) < 3)
                v = amp - $urandom_range(0, amp / 4);
            else
                v = $urandom_range(0, 400) - 200;
            send_sample(16'(v), 1'b1);
        end
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed extremes
        for (k = 0; k < 24; k++)
            case (k % 4)
                0: send_sample(16'sh7FFF, k < 12);
                1: send_sample(-16'sh8000, k < 12);
                2: send_sample(16'sh0000, 1'b0);
                default: send_sample(16'(k * 1234), 1'b0);
            endcase

        send_ecg(300, 60, 20000);

        write_reg(REG_THR_WINDOW, 16'd32);
        write_reg(REG_HOLDOFF, 16'd1);
        write_reg(REG_FORGET_FACTOR, 16'd6554);
        write_reg(REG_HP_GAIN, 16'd65535);
        send_ecg(300, 25, 30000);

        write_reg(REG_THR_WINDOW, 16'd1023);
        write_reg(REG_HOLDOFF, 16'd255);
        write_reg(REG_FORGET_FACTOR, 16'd655);
        write_reg(REG_HP_GAIN, 16'd0);
        send_ecg(300, 80, 32767);

        write_reg(REG_THR_WINDOW, 16'd0);
        write_reg(REG_HOLDOFF, 16'd0);
        write_reg(REG_FORGET_FACTOR, 16'h1FFF);
        write_reg(REG_HP_GAIN, 16'd9362);
        send_ecg(250, 15, 25000);

        write_reg(REG_THR_WINDOW, 16'd64);
        write_reg(REG_HOLDOFF, 16'd20);
        write_reg(REG_FORGET_FACTOR, 16'd3604);
        write_reg(REG_HP_GAIN, 16'd12000);
        send_ecg(250, 40, 15000);

        // uniform noise, with no gaps for the first 151 samples and random gaps after
        for (k = 0; k < 300; k++)
            send_sample(16'($urandom_range(0, 65535)), k > 150);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
